// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/scm_pkg.sv =====
// Shared types, constants and CRC function of the register slave.
`default_nettype none
package scm_pkg;
  localparam int DEF_REG_DEPTH = 256;
  localparam int DEF_MAX_READ = 4;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0] EXC_CRC = 8'hFF;
  localparam logic [7:0] EXC_RANGE = 8'hFE;
  localparam logic [2:0] LAST_BYTE = 3'd7;
  localparam logic [2:0] CRC_HI_BYTE = 3'd6;

  localparam logic [2:0] CFG_ADDR = 3'd0;
  localparam logic [2:0] CFG_WRITE = 3'd1;
  localparam logic [2:0] CFG_READ = 3'd2;
  localparam logic [2:0] CFG_VALID = 3'd3;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_CRC = 2'd2;
  localparam logic [1:0] KIND_REJ = 2'd3;

  typedef enum logic [1:0] {OP_CRC_ERR, OP_WRITE, OP_READ} op_t;
  typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_CAPT, ST_SEND} bstate_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] addr;
    logic [7:0] fc;
    logic [7:0] b2;
    logic [7:0] reg_idx;
    logic [7:0] b4;
    logic [7:0] b5;
  } cmd_t;

  typedef struct packed {
    logic [7:0] slave_address;
    logic [7:0] write_code;
    logic [7:0] read_code;
    logic [8:0] valid_registers;
  } cfg_t;

  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/modbus_like_register_slave_core.sv =====
// Top level of the register slave: config registers, front, queue and back.
// The front takes a frame one word per cycle while rx_ready is high, stalling only on
// its last word while two commands wait; a command then passes the queue, ST_FETCH and
// ST_CAPT per read register, then ST_SEND, which registers its reply words. The single
// reply sequencer sends one word per cycle while tx_ready is high, 4 to 14 per reply.
// Reset: config returns to address 1, codes 6/3, 256 registers; register file reads
// zero at once through per-entry valid bits, so no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module modbus_like_register_slave_core #(
  parameter int REG_DEPTH = scm_pkg::DEF_REG_DEPTH,
  parameter int MAX_READ_REGS = scm_pkg::DEF_MAX_READ
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  output logic            rx_ready,
  input  wire logic [7:0] rx_byte,
  output logic            tx_valid,
  input  wire logic       tx_ready,
  output logic [7:0]      tx_byte,
  output logic            tx_last,
  output logic [1:0]      reply_kind,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [8:0] cfg_data
);
  import scm_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t head;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  // Config writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_address   <= 8'd1;
      cfg.write_code      <= 8'd6;
      cfg.read_code       <= 8'd3;
      cfg.valid_registers <= 9'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ADDR:  cfg.slave_address <= cfg_data[7:0];
        CFG_WRITE: cfg.write_code <= cfg_data[7:0];
        CFG_READ:  cfg.read_code <= cfg_data[7:0];
        CFG_VALID: cfg.valid_registers <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: collect words into frames and classify them.
  scm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .rx_valid(rx_valid),
    .rx_ready(rx_ready),
    .rx_byte (rx_byte),
    .push    (q_push),
    .push_cmd(push_cmd),
    .full    (q_full)
  );

  // Queue: hold classified commands so front and back stall independently.
  scm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .head    (head),
    .empty   (q_empty)
  );

  // Back: execute commands and stream reply words.
  scm_back #(.REG_DEPTH(REG_DEPTH), .MAX_READ_REGS(MAX_READ_REGS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (q_empty),
    .head      (head),
    .pop       (q_pop),
    .tx_valid  (tx_valid),
    .tx_ready  (tx_ready),
    .tx_byte   (tx_byte),
    .tx_last   (tx_last),
    .reply_kind(reply_kind)
  );

  `ASSERT_IMPL(a_no_overflow, clk, rst, q_push, !q_full)
  `ASSERT_IMPL(a_no_underflow, clk, rst, q_pop, !q_empty)
  `ASSERT_NEXT(a_push_lands, clk, rst, q_push && !q_pop, !q_empty)
endmodule
`default_nettype wire

// ===== rtl/scm_ram.sv =====
// Generic single write port RAM with registered read.
`default_nettype none
module scm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/scm_queue.sv =====
// Two-entry command queue between front and back.
`default_nettype none
module scm_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire scm_pkg::cmd_t push_cmd,
  output logic              full,
  input  wire logic         pop,
  output scm_pkg::cmd_t     head,
  output logic              empty
);
  import scm_pkg::*;

  cmd_t       entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/scm_front.sv =====
// Front part: collects request frames, checks CRC and classifies them.
`default_nettype none
module scm_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire scm_pkg::cfg_t cfg,
  input  wire logic          rx_valid,
  output logic               rx_ready,
  input  wire logic [7:0]    rx_byte,
  output logic               push,
  output scm_pkg::cmd_t      push_cmd,
  input  wire logic          full
);
  import scm_pkg::*;

  logic [2:0]  byte_count;
  logic [15:0] crc;
  logic [7:0]  crc_hi;
  cmd_t        cur;
  logic        take;
  logic        bad;

  assign rx_ready = !(byte_count == LAST_BYTE && full);
  assign take     = rx_valid && rx_ready;
  assign bad      = ({crc_hi, rx_byte} != crc);

  always_comb begin
    push_cmd = cur;
    push     = 1'b0;
    if (bad) begin
      push_cmd.op = OP_CRC_ERR;
    end else if (cur.fc == cfg.write_code) begin
      push_cmd.op = OP_WRITE;
    end else begin
      push_cmd.op = OP_READ;
    end
    if (take && byte_count == LAST_BYTE) begin
      // drop frames with an unknown function code unless their CRC is bad
      push = bad || cur.fc == cfg.write_code || cur.fc == cfg.read_code;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      unique case (byte_count)
        3'd0: cur.addr <= rx_byte;
        3'd1: cur.fc <= rx_byte;
        3'd2: cur.b2 <= rx_byte;
        3'd3: cur.reg_idx <= rx_byte;
        3'd4: cur.b4 <= rx_byte;
        3'd5: cur.b5 <= rx_byte;
        3'd6: crc_hi <= rx_byte;
        default: ;
      endcase
      if (byte_count == 3'd0) begin
        crc <= crc_byte(CRC_INIT, rx_byte);
      end else if (byte_count < CRC_HI_BYTE) begin
        crc <= crc_byte(crc, rx_byte);
      end
    end
    cur.op <= OP_READ;
    if (rst) begin
      byte_count <= 3'd0;
    end else if (take) begin
      if (byte_count != 3'd0 || rx_byte == cfg.slave_address) begin
        byte_count <= byte_count + 3'd1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/scm_back.sv =====
// Back part: executes commands on the register file and sends replies.
`default_nettype none
module scm_back #(
  parameter int REG_DEPTH = scm_pkg::DEF_REG_DEPTH,
  parameter int MAX_READ_REGS = scm_pkg::DEF_MAX_READ
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire scm_pkg::cfg_t cfg,
  input  wire logic          empty,
  input  wire scm_pkg::cmd_t head,
  output logic               pop,
  output logic               tx_valid,
  input  wire logic          tx_ready,
  output logic [7:0]         tx_byte,
  output logic               tx_last,
  output logic [1:0]         reply_kind
);
  import scm_pkg::*;

  localparam int AW = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1;
  localparam int CW = $clog2(MAX_READ_REGS + 1);
  localparam int RW = (MAX_READ_REGS > 1) ? $clog2(MAX_READ_REGS) : 1;
  localparam logic [8:0] DEPTH9 = 9'(REG_DEPTH);
  localparam logic [CW-1:0] MAXC = CW'(MAX_READ_REGS);

  bstate_t     state, state_next;
  cmd_t        cmd;
  logic [1:0]  kind;
  logic [3:0]  dlen;
  logic [3:0]  k;
  logic [CW-1:0] j;
  logic [CW-1:0] cnt;
  logic [15:0] crc;
  logic [15:0] rdv [MAX_READ_REGS];
  logic [REG_DEPTH-1:0] vbits;
  logic        ok_q;
  logic [15:0] rdata;
  logic        wr_ok;
  logic        we;
  logic [8:0]  ridx;
  logic [AW-1:0] raddr;
  logic        slot_free;
  logic        load;
  logic [7:0]  dbyte;
  logic [3:0]  roff;
  logic [15:0] rsel;
  logic [CW-1:0] hcnt;

  assign wr_ok = ({1'b0, head.reg_idx} < cfg.valid_registers) &&
                 ({1'b0, head.reg_idx} < DEPTH9);
  assign we    = pop && head.op == OP_WRITE && wr_ok;
  assign ridx  = {1'b0, cmd.reg_idx} + 9'(j);
  assign raddr = ridx[AW-1:0];
  assign hcnt  = (head.b5 > 8'(MAX_READ_REGS)) ? MAXC : head.b5[CW-1:0];
  assign slot_free = !tx_valid || tx_ready;
  assign load  = state == ST_SEND && slot_free;
  assign roff  = k - 4'd4;
  assign rsel  = rdv[roff[RW:1]];

  scm_ram #(.WIDTH(16), .DEPTH(REG_DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(head.reg_idx[AW-1:0]),
    .wdata({head.b4, head.b5}),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    dbyte = 8'h00;
    if (k >= dlen) begin
      dbyte = (k == dlen) ? crc[15:8] : crc[7:0];
    end else if (k == 4'd1 && kind == KIND_CRC) begin
      dbyte = EXC_CRC;
    end else if (k == 4'd1 && kind == KIND_REJ) begin
      dbyte = EXC_RANGE;
    end else if (k < 4'd4 || kind == KIND_ECHO) begin
      unique case (k[2:0])
        3'd0: dbyte = cmd.addr;
        3'd1: dbyte = cmd.fc;
        3'd2: dbyte = cmd.b2;
        3'd3: dbyte = cmd.reg_idx;
        3'd4: dbyte = cmd.b4;
        3'd5: dbyte = cmd.b5;
        default: dbyte = 8'h00;
      endcase
    end else begin
      dbyte = roff[0] ? rsel[7:0] : rsel[15:8];
    end
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (head.op == OP_READ && hcnt != '0) begin
            state_next = ST_FETCH;
          end else begin
            state_next = ST_SEND;
          end
        end
      end
      ST_FETCH: state_next = ST_CAPT;
      ST_CAPT:  state_next = (j + CW'(1) == cnt) ? ST_SEND : ST_FETCH;
      ST_SEND: begin
        if (slot_free && k + 4'd1 == dlen + 4'd2) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head;
      k   <= 4'd0;
      j   <= '0;
      cnt <= hcnt;
      crc <= CRC_INIT;
      unique case (head.op)
        OP_CRC_ERR: begin
          kind <= KIND_CRC;
          dlen <= 4'd2;
        end
        OP_WRITE: begin
          kind <= wr_ok ? KIND_ECHO : KIND_REJ;
          dlen <= wr_ok ? 4'd6 : 4'd2;
        end
        default: begin
          kind <= KIND_READ;
          dlen <= 4'd4 + (4'(hcnt) << 1);
        end
      endcase
    end
    if (state == ST_FETCH) begin
      ok_q <= ridx < cfg.valid_registers && ridx < DEPTH9 && vbits[raddr];
    end
    if (state == ST_CAPT) begin
      rdv[j[RW-1:0]] <= ok_q ? rdata : 16'h0000;
      j <= j + CW'(1);
    end
    if (load) begin
      tx_byte    <= dbyte;
      tx_last    <= (k + 4'd1 == dlen + 4'd2);
      reply_kind <= kind;
      k          <= k + 4'd1;
      if (k < dlen) begin
        crc <= crc_byte(crc, dbyte);
      end
    end
    if (rst) begin
      tx_valid <= 1'b0;
      vbits    <= '0;
    end else begin
      if (load) begin
        tx_valid <= 1'b1;
      end else if (tx_ready) begin
        tx_valid <= 1'b0;
      end
      if (we) begin
        vbits[head.reg_idx[AW-1:0]] <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire
